### design/assert_macros.svh
// Assertion macros for the square matrix multiply block.
// Included by files that carry concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMM_ASSERT(lbl, prop, msg)
`define SMM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### design/smm_pkg.sv
// Shared types, constants and helpers for the square matrix multiply block.
// No dependencies; used by smm_store, smm_mac, square_matrix_multiply and tb.
package smm_pkg;

    localparam int MAX_N       = 8;
    localparam int SIZE_W      = 4;
    localparam int IDX_W       = 3;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 40;
    localparam int DEPTH       = MAX_N * MAX_N;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_MAC   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_PUT   = 4'b1000
    } state_t;

    typedef struct packed {
        logic              en;
        logic              sel_right;
        logic [ADDR_W-1:0] addr;
    } store_wr_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

    // Clamp the size register into 1..MAX_N.
    function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] n;
        n = sz;
        if (sz == '0)
        begin
            n = SIZE_W'(1);
        end
        else if (sz > SIZE_W'(MAX_N))
        begin
            n = SIZE_W'(MAX_N);
        end
        return n;
    endfunction

endpackage

### design/square_matrix_multiply.sv
// Square matrix multiply, top level: load sequencer, product sequencer, output register.
// Depends on smm_pkg, smm_store, smm_mac and assert_macros.svh.
//
// The block multiplies two n x n matrices of signed Q1.15 elements, n taken from the
// size register (0 acts as 1, above 8 acts as 8). Elements arrive one per
// transaction: the n*n left elements row-major, then the n*n right elements
// row-major. The transaction carrying the last right element starts the product,
// and n*n results leave row-major, each the exact Q10.30 sum of n products, with
// last set on the final one. All products run through a single multiply-accumulate
// unit fed from two single-read-port stores, one product term per cycle; each
// result passes the read, multiply and accumulate registers before it is placed in
// the output register. No element is accepted while a product is in progress; the
// output register lets the next result be computed while the current one waits,
// and the block accepts new elements as soon as the final result is placed. Writing
// the size register restarts the load; write it only while the block is idle. A
// pending size write holds off elements until it is taken. The stores need no
// clearing after reset.
`include "assert_macros.svh"

module square_matrix_multiply (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [smm_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [smm_pkg::ELEM_W-1:0]     element,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic        [smm_pkg::IDX_W-1:0]      row,
    output logic        [smm_pkg::IDX_W-1:0]      col,
    output logic signed [smm_pkg::ACC_W-1:0]      product,
    output logic                                  last
);

    smm_pkg::state_t state_reg, state_next;

    logic [smm_pkg::SIZE_W-1:0] size_reg;
    logic [smm_pkg::CNT_W-1:0]  load_count_reg, load_count_next;
    logic [smm_pkg::IDX_W-1:0]  r_reg, r_next;
    logic [smm_pkg::IDX_W-1:0]  c_reg, c_next;
    logic [smm_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [smm_pkg::ADDR_W-1:0] lbase_reg, lbase_next;
    logic [smm_pkg::ADDR_W-1:0] raddr_reg, raddr_next;

    logic                                out_valid_reg, out_valid_next;
    logic        [smm_pkg::IDX_W-1:0]    row_reg;
    logic        [smm_pkg::IDX_W-1:0]    col_reg;
    logic signed [smm_pkg::ACC_W-1:0]    product_reg;
    logic                                last_reg;

    logic [smm_pkg::SIZE_W-1:0]  n;
    logic [smm_pkg::IDX_W-1:0]   n_max;
    logic [2*smm_pkg::SIZE_W-1:0] nn_full;
    logic [smm_pkg::CNT_W-1:0]   nn;
    logic [smm_pkg::CNT_W:0]     last_load_full;
    logic [smm_pkg::CNT_W-1:0]   right_off;
    logic [smm_pkg::CNT_W-1:0]   raddr_step;

    logic in_fire;
    logic cfg_fire;
    logic out_fire;
    logic slot_free;
    logic put_fire;
    logic put_last;

    smm_pkg::store_wr_t                   wr;
    smm_pkg::mac_ctrl_t                   issue_ctrl;
    smm_pkg::mac_ctrl_t                   issue_ctrl_reg;
    logic        [smm_pkg::ADDR_W-1:0]    laddr;
    logic signed [smm_pkg::ELEM_W-1:0]    rd_left;
    logic signed [smm_pkg::ELEM_W-1:0]    rd_right;
    logic signed [smm_pkg::ACC_W-1:0]     mac_acc;
    logic                                 mac_done;

    // Derived sizes
    assign n              = smm_pkg::active_size(size_reg);
    assign n_max          = smm_pkg::IDX_W'(n - smm_pkg::SIZE_W'(1));
    assign nn_full        = {{smm_pkg::SIZE_W{1'b0}}, n} * {{smm_pkg::SIZE_W{1'b0}}, n};
    assign nn             = nn_full[smm_pkg::CNT_W-1:0];
    assign last_load_full = {nn, 1'b0} - (smm_pkg::CNT_W+1)'(1);
    assign right_off      = load_count_reg - nn;
    assign raddr_step     = smm_pkg::CNT_W'(raddr_reg) + smm_pkg::CNT_W'(n);

    // Handshakes; hold off elements while a size write waits so none is dropped
    assign in_ready  = (state_reg == smm_pkg::S_LOAD) && !cfg_valid;
    assign cfg_ready = (state_reg == smm_pkg::S_LOAD);
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign put_fire  = (state_reg == smm_pkg::S_PUT) && slot_free;
    assign put_last  = (r_reg == n_max) && (c_reg == n_max);

    // Store write: left half of the load first, then the right half
    always_comb
    begin
        wr.en        = in_fire;
        wr.sel_right = (load_count_reg >= nn);
        wr.addr      = wr.sel_right ? right_off[smm_pkg::ADDR_W-1:0]
                                    : load_count_reg[smm_pkg::ADDR_W-1:0];
    end

    assign laddr = lbase_reg + smm_pkg::ADDR_W'(k_reg);

    // One product term per cycle while in S_MAC
    always_comb
    begin
        issue_ctrl.valid = (state_reg == smm_pkg::S_MAC);
        issue_ctrl.first = (k_reg == '0);
        issue_ctrl.last  = (k_reg == n_max);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        k_next          = k_reg;
        lbase_next      = lbase_reg;
        raddr_next      = raddr_reg;

        unique case (state_reg)
            smm_pkg::S_LOAD:
            begin
                if (cfg_fire)
                begin
                    // new size: drop any partial load
                    load_count_next = '0;
                end
                else if (in_fire)
                begin
                    if (load_count_reg == last_load_full[smm_pkg::CNT_W-1:0])
                    begin
                        load_count_next = '0;
                        r_next          = '0;
                        c_next          = '0;
                        k_next          = '0;
                        lbase_next      = '0;
                        raddr_next      = '0;
                        state_next      = smm_pkg::S_MAC;
                    end
                    else
                    begin
                        load_count_next = load_count_reg + smm_pkg::CNT_W'(1);
                    end
                end
            end
            smm_pkg::S_MAC:
            begin
                if (k_reg == n_max)
                begin
                    k_next     = '0;
                    raddr_next = smm_pkg::ADDR_W'(c_reg);
                    state_next = smm_pkg::S_DRAIN;
                end
                else
                begin
                    k_next     = k_reg + smm_pkg::IDX_W'(1);
                    raddr_next = raddr_step[smm_pkg::ADDR_W-1:0];
                end
            end
            smm_pkg::S_DRAIN:
            begin
                if (mac_done)
                begin
                    state_next = smm_pkg::S_PUT;
                end
            end
            smm_pkg::S_PUT:
            begin
                if (slot_free)
                begin
                    if (put_last)
                    begin
                        state_next = smm_pkg::S_LOAD;
                    end
                    else
                    begin
                        // advance to the next result, row-major
                        if (c_reg == n_max)
                        begin
                            c_next     = '0;
                            r_next     = r_reg + smm_pkg::IDX_W'(1);
                            lbase_next = lbase_reg + smm_pkg::ADDR_W'(n);
                            raddr_next = '0;
                        end
                        else
                        begin
                            c_next     = c_reg + smm_pkg::IDX_W'(1);
                            raddr_next = smm_pkg::ADDR_W'(c_reg + smm_pkg::IDX_W'(1));
                        end
                        state_next = smm_pkg::S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = smm_pkg::S_LOAD;
            end
        endcase
    end

    // Output register: hold until taken, reload from the accumulator on a put
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (put_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= smm_pkg::S_LOAD;
            size_reg       <= smm_pkg::SIZE_W'(smm_pkg::MAX_N);
            load_count_reg <= '0;
            r_reg          <= '0;
            c_reg          <= '0;
            k_reg          <= '0;
            lbase_reg      <= '0;
            raddr_reg      <= '0;
            out_valid_reg  <= 1'b0;
            issue_ctrl_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            k_reg          <= k_next;
            lbase_reg      <= lbase_next;
            raddr_reg      <= raddr_next;
            out_valid_reg  <= out_valid_next;
            issue_ctrl_reg <= issue_ctrl;
            if (cfg_fire)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (put_fire)
        begin
            row_reg     <= r_reg;
            col_reg     <= c_reg;
            product_reg <= mac_acc;
            last_reg    <= put_last;
        end
    end

    smm_store u_store (
        .clk         (clk),
        .wr          (wr),
        .wdata       (element),
        .raddr_left  (laddr),
        .raddr_right (raddr_reg),
        .rdata_left  (rd_left),
        .rdata_right (rd_right)
    );

    // control registered to line up with the registered read data
    smm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (issue_ctrl_reg),
        .a     (rd_left),
        .b     (rd_right),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign out_valid = out_valid_reg;
    assign row       = row_reg;
    assign col       = col_reg;
    assign product   = product_reg;
    assign last      = last_reg;

    // Checks
    `SMM_ASSERT(a_done_drain, mac_done |-> (state_reg == smm_pkg::S_DRAIN), "done outside drain")
    `SMM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(product), "dropped")
    `SMM_ASSERT(a_no_load_busy, (state_reg != smm_pkg::S_LOAD) |-> !in_ready, "load while busy")

endmodule

### design/smm_store.sv
// Left and right matrix stores: one write port, one registered read port each.
// Depends on smm_pkg.
module smm_store (
    input  logic                                 clk,
    input  smm_pkg::store_wr_t                   wr,
    input  logic signed [smm_pkg::ELEM_W-1:0]    wdata,
    input  logic        [smm_pkg::ADDR_W-1:0]    raddr_left,
    input  logic        [smm_pkg::ADDR_W-1:0]    raddr_right,
    output logic signed [smm_pkg::ELEM_W-1:0]    rdata_left,
    output logic signed [smm_pkg::ELEM_W-1:0]    rdata_right
);

    logic signed [smm_pkg::ELEM_W-1:0] left_mem  [0:smm_pkg::DEPTH-1];
    logic signed [smm_pkg::ELEM_W-1:0] right_mem [0:smm_pkg::DEPTH-1];
    logic signed [smm_pkg::ELEM_W-1:0] rdata_left_reg;
    logic signed [smm_pkg::ELEM_W-1:0] rdata_right_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en && !wr.sel_right)
        begin
            left_mem[wr.addr] <= wdata;
        end
        rdata_left_reg <= left_mem[raddr_left];
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.sel_right)
        begin
            right_mem[wr.addr] <= wdata;
        end
        rdata_right_reg <= right_mem[raddr_right];
    end

    assign rdata_left  = rdata_left_reg;
    assign rdata_right = rdata_right_reg;

endmodule

### design/smm_mac.sv
// Shared multiply-accumulate unit: registered 16x16 multiply, then 40-bit accumulate.
// Depends on smm_pkg.
module smm_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  smm_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [smm_pkg::ELEM_W-1:0]    a,
    input  logic signed [smm_pkg::ELEM_W-1:0]    b,
    output logic signed [smm_pkg::ACC_W-1:0]     acc,
    output logic                                 done
);

    logic signed [smm_pkg::PROD_W-1:0] prod_reg;
    smm_pkg::mac_ctrl_t                ctrl_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [smm_pkg::ACC_W-1:0]  acc_next;
    logic signed [smm_pkg::ACC_W-1:0]  prod_ext;
    logic                              done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctrl_reg <= ctrl;
            done_reg <= ctrl_reg.valid && ctrl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign prod_ext = smm_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl_reg.valid)
        begin
            // first term restarts the sum
            acc_next = ctrl_reg.first ? prod_ext : acc_reg + prod_ext;
        end
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

### dv/tb.sv
// Self-checking testbench for square_matrix_multiply: directed table, then random phases.
// Depends on smm_pkg and the square_matrix_multiply RTL; needs no other files.
// Predicts every product element in the bench and checks each result transaction in order.
module tb;

    // Idle stretch before the set-up writes, once the queue of expected results is empty.
    localparam int SETTLE_CYCLES  = 16;
    // Long receiver hold-off for the back-pressure phase.
    localparam int HOLD_CYCLES    = 200;
    // Cycles with no transaction on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [smm_pkg::IDX_W-1:0]        row;
        logic [smm_pkg::IDX_W-1:0]        col;
        logic signed [smm_pkg::ACC_W-1:0] product;
        logic                             last;
    } result_t;

    typedef enum {ROW_ELEMENT, ROW_SIZE} row_kind_t;

    // One line of the directed table: an element or a size write, with the product
    // typed in where it is obvious. A typed product applies to every result of the row.
    typedef struct {
        row_kind_t kind;
        logic [15:0] value;
        bit        has_typed;
        longint    typed_product;
    } stim_row_t;

    typedef enum {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

    typedef struct {
        logic [smm_pkg::SIZE_W-1:0] size_code;
        pace_t pace;
        int    sets;
        bit    restart_mid_load;
        bit    hold_output;
    } phase_t;

    logic                                clk;
    logic                                rst_n     = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic        [smm_pkg::SIZE_W-1:0]   cfg_data  = '0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic signed [smm_pkg::ELEM_W-1:0]   element   = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic        [smm_pkg::IDX_W-1:0]    row;
    logic        [smm_pkg::IDX_W-1:0]    col;
    logic signed [smm_pkg::ACC_W-1:0]    product;
    logic                                last;

    // Bench copy of the block state.
    logic [smm_pkg::SIZE_W-1:0]        size_reg = 4'd8;
    logic signed [smm_pkg::ELEM_W-1:0] left_mat  [smm_pkg::DEPTH];
    logic signed [smm_pkg::ELEM_W-1:0] right_mat [smm_pkg::DEPTH];
    int unsigned                       loaded = 0;

    result_t pending_products[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;

    stim_row_t directed_rows [26];
    phase_t    phases [6];

    square_matrix_multiply dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .element   (element),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row       (row),
        .col       (col),
        .product   (product),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Rows and columns in use: zero counts as one, anything above the maximum as the maximum.
    function automatic int unsigned matrix_dim();
        if (size_reg == '0)
        begin
            return 1;
        end
        if (size_reg > smm_pkg::MAX_N)
        begin
            return smm_pkg::MAX_N;
        end
        return size_reg;
    endfunction

    // Store one element; on the last right-matrix element queue the whole product
    // row-major and return how many results it makes.
    function automatic int unsigned load_and_multiply(input logic signed [15:0] value);
        int unsigned n;
        int unsigned nn;
        longint      acc;
        result_t     res;
        n  = matrix_dim();
        nn = n * n;
        if (loaded >= 2 * nn)
        begin
            loaded = 0;
        end
        if (loaded < nn)
        begin
            left_mat[loaded] = value;
        end
        else
        begin
            right_mat[loaded - nn] = value;
        end
        loaded++;
        if (loaded < 2 * nn)
        begin
            return 0;
        end
        loaded = 0;
        for (int unsigned r = 0; r < n; r++)
        begin
            for (int unsigned c = 0; c < n; c++)
            begin
                acc = 0;
                for (int unsigned k = 0; k < n; k++)
                begin
                    acc += longint'(left_mat[r * n + k]) * longint'(right_mat[k * n + c]);
                end
                res.row     = r[smm_pkg::IDX_W-1:0];
                res.col     = c[smm_pkg::IDX_W-1:0];
                res.product = acc[smm_pkg::ACC_W-1:0];
                res.last    = (r == n - 1) && (c == n - 1);
                pending_products.push_back(res);
            end
        end
        return nn;
    endfunction

    function automatic logic [15:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one element, with an optional random gap first, and return at the edge
    // that accepts it. Leave valid high so back-to-back transactions need no toggle.
    task automatic push_element(input logic [15:0] value);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        element  <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold until every expected result has arrived, then let the block settle.
    task automatic wait_drained();
        while (pending_products.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the size register with the input side quiet; this also restarts the load.
    task automatic write_size(input logic [smm_pkg::SIZE_W-1:0] code);
        in_valid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = code;
        loaded   = 0;
    endtask

    task automatic note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
    endtask

    // Receiver: stall at the current rate, or hold off for a long stretch on request
    // so the output register fills and the block stops taking elements.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Check every accepted result against the oldest expected product element.
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_products.size() == 0)
            begin
                note_failure($sformatf("unexpected result: row %0d col %0d product %0d last %0b",
                                       row, col, product, last));
            end
            else
            begin
                want = pending_products.pop_front();
                if (row !== want.row || col !== want.col || product !== want.product ||
                    last !== want.last)
                begin
                    note_failure($sformatf(
                        "mismatch: want r%0d c%0d p%0d l%0b, got r%0d c%0d p%0d l%0b",
                        want.row, want.col, want.product, want.last, row, col, product, last));
                end
            end
        end
    end

    // Watchdog: count cycles in which no channel completes a transaction.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[square_matrix_multiply] ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned made;
        int unsigned n;
        int unsigned partial;

        // Directed part. The first three elements load under the reset size and are
        // then dropped by a size write in the middle of the load. Single-element
        // matrices give the extreme products, size zero must act as one, and a
        // 2x2 pair of all most-negative values gives the largest sums.
        directed_rows = '{
            '{ROW_ELEMENT, 16'h7FFF, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h1234, 1'b0, 64'sd0},
            '{ROW_SIZE,    16'd1,    1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b1, 64'sd1073741824},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h7FFF, 1'b1, -64'sd1073709056},
            '{ROW_ELEMENT, 16'h7FFF, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h7FFF, 1'b1, 64'sd1073676289},
            '{ROW_ELEMENT, 16'h0000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b1, 64'sd0},
            '{ROW_ELEMENT, 16'hFFFF, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'hFFFF, 1'b1, 64'sd1},
            '{ROW_SIZE,    16'd0,    1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h0001, 1'b1, -64'sd32768},
            '{ROW_SIZE,    16'd2,    1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b0, 64'sd0},
            '{ROW_ELEMENT, 16'h8000, 1'b1, 64'sd2147483648}
        };

        // Random phases: size, pacing, full pairs, an abandoned load, back-pressure.
        phases = '{
            '{4'd2,  PACE_FULL,       2, 1'b0, 1'b0},
            '{4'd3,  PACE_SEND_IDLE,  1, 1'b1, 1'b0},
            '{4'd1,  PACE_RECV_STALL, 3, 1'b0, 1'b0},
            '{4'd4,  PACE_BOTH,       1, 1'b0, 1'b0},
            '{4'd2,  PACE_FULL,       3, 1'b0, 1'b1},
            '{4'd0,  PACE_SEND_IDLE,  3, 1'b0, 1'b0}
        };

        // Hold reset low, then release it on a clock edge.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_SIZE)
            begin
                write_size(directed_rows[i].value[smm_pkg::SIZE_W-1:0]);
            end
            else
            begin
                push_element(directed_rows[i].value);
                made = load_and_multiply(directed_rows[i].value);
                // Override the predicted products with the typed-in ones for this row.
                if (directed_rows[i].has_typed)
                begin
                    for (int unsigned j = 1; j <= made; j++)
                    begin
                        pending_products[pending_products.size() - j].product =
                            directed_rows[i].typed_product[smm_pkg::ACC_W-1:0];
                    end
                end
            end
        end

        foreach (phases[p])
        begin
            write_size(phases[p].size_code);
            case (phases[p].pace)
                PACE_FULL:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                PACE_SEND_IDLE:  begin send_idle_pct = 48; recv_stall_pct = 0;  end
                PACE_RECV_STALL: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default:         begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            n = matrix_dim();
            // Abandon a partial load, then restart it with a size write.
            if (phases[p].restart_mid_load)
            begin
                partial = $urandom_range(1, 2 * n * n - 1);
                repeat (partial)
                begin
                    element_feed : begin
                        logic [15:0] v;
                        v = random_element();
                        push_element(v);
                        void'(load_and_multiply(v));
                    end
                end
                write_size(phases[p].size_code);
            end
            // Stall the output while the sender keeps offering the next pairs.
            if (phases[p].hold_output)
            begin
                hold_request = 1'b1;
            end
            repeat (phases[p].sets * 2 * n * n)
            begin
                element_feed_full : begin
                    logic [15:0] v;
                    v = random_element();
                    push_element(v);
                    void'(load_and_multiply(v));
                end
            end
        end

        // Drop valid, drain all outstanding results and report.
        in_valid <= 1'b0;
        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("[square_matrix_multiply] OK");
        end
        else
        begin
            $display("[square_matrix_multiply] ERROR");
        end
        $finish;
    end

endmodule
